@@ design/twhbt_pkg.sv @@
// Package for the two-wire handshake byte transfer unit.
// Holds the beat payload types, command codes and bit constants.
// No dependencies.
package twhbt_pkg;

   // command codes carried in the kind field
   localparam logic [2:0] KIND_TICK      = 3'd0;
   localparam logic [2:0] KIND_SEND      = 3'd1;
   localparam logic [2:0] KIND_RECV      = 3'd2;
   localparam logic [2:0] KIND_CHK_WRITE = 3'd3;
   localparam logic [2:0] KIND_CHK_READ  = 3'd4;
   localparam logic [2:0] KIND_ST_WRITE  = 3'd5;
   localparam logic [2:0] KIND_ST_READ   = 3'd6;

   // receive shifts the new bit in at the top; sends run MSB first
   localparam logic [7:0] TOP_BIT    = 8'h80;
   localparam logic [2:0] LAST_INDEX = 3'd7;

   // one input beat: a sampled tick, possibly with a command
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic       clock_asserted;
      logic       data_asserted;
   } req_type;

   // one result beat: line drives and status after the tick
   typedef struct packed {
      logic       drive_clock;
      logic       drive_data;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       check_failed;
   } rsp_type;

endpackage

@@ design/two_wire_handshake_byte_transfer_unit.sv @@
// Top level of the two-wire handshake byte transfer unit (host side).
// Depends on twhbt_pkg for payload types and command codes.
//
// One request beat is one sampled tick of the clock and data lines and may
// start a command (start write/read, send byte, receive byte, error check).
// Each tick advances the transfer sequencer by at most one step and yields
// exactly one response beat with the host line drives and status. A tick is
// accepted every clock while req_stall is low; its response is registered,
// in the skid register if the output is held. The sequencer state register
// is the only loop, updated once per tick. A two-entry output stage (output
// register plus skid register) lets a new tick be accepted while a response
// waits; req_stall is high only when both entries are full.
module two_wire_handshake_byte_transfer_unit
   import twhbt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // sequencer phases
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_W_CLK1   = 4'd1;
   localparam logic [3:0] PH_W_CLK0   = 4'd2;
   localparam logic [3:0] PH_W_DATA1  = 4'd3;
   localparam logic [3:0] PH_R_DATA0  = 4'd4;
   localparam logic [3:0] PH_R_SAMPLE = 4'd5;
   localparam logic [3:0] PH_R_CLKCHG = 4'd6;
   localparam logic [3:0] PH_R_DATA1  = 4'd7;
   localparam logic [3:0] PH_C_DATA0  = 4'd8;
   localparam logic [3:0] PH_C_CLK0   = 4'd9;
   localparam logic [3:0] PH_C_DATA1  = 4'd10;
   localparam logic [3:0] PH_S_DATA1  = 4'd11;

   logic [3:0] phase_ff, phase_in;
   logic [2:0] command_ff, command_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic       sampled_ff, sampled_in;
   logic       clk_drv_ff, clk_drv_in;
   logic       dat_drv_ff, dat_drv_in;
   logic       fail_ff, fail_in;
   logic       done;

   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   logic       skid_valid_ff;
   rsp_type    skid_ff;
   rsp_type    result;
   logic       req_acc;
   logic       out_free;

   logic clk_s, dat_s;
   assign clk_s = req_data.clock_asserted;
   assign dat_s = req_data.data_asserted;

   // output stage handshake
   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one sequencer step per tick
   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      sampled_in   = sampled_ff;
      clk_drv_in   = clk_drv_ff;
      dat_drv_in   = dat_drv_ff;
      fail_in      = fail_ff;
      done         = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            unique case (req_data.kind)
               KIND_SEND: begin
                  command_in   = req_data.kind;
                  shift_in     = req_data.tx_byte;
                  bit_count_in = LAST_INDEX;
                  dat_drv_in   = req_data.tx_byte[LAST_INDEX];
                  clk_drv_in   = 1'b0;
                  phase_in     = PH_W_CLK1;
               end
               KIND_RECV: begin
                  command_in   = req_data.kind;
                  shift_in     = 8'h00;
                  bit_count_in = LAST_INDEX;
                  phase_in     = PH_R_DATA0;
               end
               KIND_CHK_WRITE, KIND_CHK_READ: begin
                  command_in = req_data.kind;
                  fail_in    = 1'b0;
                  clk_drv_in = 1'b0;
                  phase_in   = PH_C_DATA0;
               end
               KIND_ST_WRITE: begin
                  command_in = req_data.kind;
                  phase_in   = PH_S_DATA1;
               end
               KIND_ST_READ: begin
                  command_in = req_data.kind;
                  clk_drv_in = 1'b0;
                  phase_in   = PH_S_DATA1;
               end
               default: begin
                  // tick only, and the unused code
               end
            endcase
         end
         PH_W_CLK1: begin
            if (clk_s) begin
               dat_drv_in = ~shift_ff[bit_count_ff];
               phase_in   = PH_W_CLK0;
            end
         end
         PH_W_CLK0: begin
            if (!clk_s) begin
               dat_drv_in = 1'b0;
               clk_drv_in = 1'b1;
               phase_in   = PH_W_DATA1;
            end
         end
         PH_W_DATA1: begin
            if (dat_s) begin
               if (bit_count_ff == 3'd0) begin
                  bit_count_in = LAST_INDEX;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
               end else begin
                  bit_count_in = bit_count_ff - 3'd1;
                  dat_drv_in   = shift_ff[bit_count_ff - 3'd1];
                  clk_drv_in   = 1'b0;
                  phase_in     = PH_W_CLK1;
               end
            end
         end
         PH_R_DATA0: begin
            if (!dat_s) begin
               clk_drv_in = 1'b0;
               phase_in   = PH_R_SAMPLE;
            end
         end
         PH_R_SAMPLE: begin
            // bit comes off the clock line
            sampled_in = clk_s;
            shift_in   = (shift_ff >> 1) | (clk_s ? TOP_BIT : 8'h00);
            dat_drv_in = 1'b1;
            phase_in   = PH_R_CLKCHG;
         end
         PH_R_CLKCHG: begin
            if (clk_s != sampled_ff) begin
               dat_drv_in = 1'b0;
               phase_in   = PH_R_DATA1;
            end
         end
         PH_R_DATA1: begin
            if (dat_s) begin
               clk_drv_in = 1'b1;
               if (bit_count_ff == 3'd0) begin
                  bit_count_in = LAST_INDEX;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
               end else begin
                  bit_count_in = bit_count_ff - 3'd1;
                  phase_in     = PH_R_DATA0;
               end
            end
         end
         PH_C_DATA0: begin
            if (!dat_s) begin
               if (!clk_s) begin
                  fail_in  = 1'b1;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  dat_drv_in = 1'b1;
                  phase_in   = PH_C_CLK0;
               end
            end
         end
         PH_C_CLK0: begin
            if (!clk_s) begin
               dat_drv_in = 1'b0;
               if (command_ff == KIND_CHK_WRITE) clk_drv_in = 1'b1;
               phase_in = PH_C_DATA1;
            end
         end
         PH_C_DATA1: begin
            if (dat_s) begin
               clk_drv_in = 1'b1;
               phase_in   = PH_IDLE;
               done       = 1'b1;
            end
         end
         PH_S_DATA1: begin
            if (dat_s) begin
               if (command_ff == KIND_ST_READ) clk_drv_in = 1'b1;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // response for this tick
   always_comb begin
      result.drive_clock  = clk_drv_in;
      result.drive_data   = dat_drv_in;
      result.busy_res     = (phase_in != PH_IDLE);
      result.done_res     = done;
      result.rx_byte      = shift_in;
      result.check_failed = fail_in;
   end

   // sequencer state, advanced on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         command_ff   <= KIND_TICK;
         bit_count_ff <= LAST_INDEX;
         shift_ff     <= 8'h00;
         sampled_ff   <= 1'b0;
         clk_drv_ff   <= 1'b0;
         dat_drv_ff   <= 1'b0;
         fail_ff      <= 1'b0;
      end else if (req_acc) begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         sampled_ff   <= sampled_in;
         clk_drv_ff   <= clk_drv_in;
         dat_drv_ff   <= dat_drv_in;
         fail_ff      <= fail_in;
      end
   end

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_acc;
         end
      end else if (req_acc) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) rsp_ff <= skid_ff;
         else if (req_acc) rsp_ff <= result;
      end else if (req_acc) begin
         skid_ff <= result;
      end
   end

   // skid entry only fills behind a held output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry full while output register empty");

   // a held skid beat must not change
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_valid_ff && rsp_stall) |=> $stable(skid_ff))
      else $error("skid beat changed while held");

   // a send command starts by waiting for clock asserted
   a_send_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && phase_ff == PH_IDLE && req_data.kind == KIND_SEND)
      |=> (phase_ff == PH_W_CLK1 && bit_count_ff == LAST_INDEX))
      else $error("send did not enter first bit wait");

   // completion always returns the sequencer to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && done) |=> (phase_ff == PH_IDLE))
      else $error("command completed but sequencer not idle");

endmodule
